>>> hw/rtl/pkd_pkg.sv
// shared types and constants for the peak detector
`default_nettype none

package pkd_pkg;

   localparam int SAMPLE_W        = 32;
   localparam int DIST_W          = 12;
   localparam int PEAK_IDX_W      = 12;
   localparam int MAX_LEN_DEFAULT = 4096;
   localparam logic [DIST_W-1:0] DIST_RESET = 12'd5;

   // results one item can cause, and the result queue around them
   localparam int MAX_RES = 3;
   localparam int RES_CNT_W = 2;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   typedef struct packed {
      logic [PEAK_IDX_W-1:0] peak_index;
      logic                  is_maximum;
      logic                  final_result;
   } res_type;

   typedef struct packed {
      logic [RES_CNT_W-1:0]     count;
      res_type [MAX_RES-1:0]    res;
   } batch_type;

endpackage

`default_nettype wire

>>> hw/rtl/pkd_core.sv
// extremum classification, pending maximum and minimum, result batch per item
`default_nettype none

module pkd_core
   import pkd_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic                last,
   input  wire logic [DIST_W-1:0]   min_peak_dist,
   output batch_type                batch
);

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [SAMPLE_W-1:0] prev_prev_ff, prev_prev_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    max_idx_ff, max_idx_in;
   logic [SAMPLE_W-1:0] max_val_ff, max_val_in;
   logic                max_valid_ff, max_valid_in;
   logic [IDX_W-1:0]    min_idx_ff, min_idx_in;
   logic [SAMPLE_W-1:0] min_val_ff, min_val_in;
   logic                min_valid_ff, min_valid_in;

   logic [CNT_W-1:0]    count_m1;
   logic [IDX_W-1:0]    idx;
   logic                cand;
   logic                is_max;
   logic                is_min;
   logic                max_near;
   logic                min_near;
   logic                conf_v;
   res_type             conf;
   logic                e0_v;
   logic                e1_v;
   res_type             e0;
   res_type             e1;

   function automatic logic [PEAK_IDX_W-1:0] to_out(input logic [IDX_W-1:0] i);
      logic [IDX_W+PEAK_IDX_W-1:0] wide;
      wide = {{PEAK_IDX_W{1'b0}}, i};
      return wide[PEAK_IDX_W-1:0];
   endfunction

   assign count_m1 = count_ff - 1'b1;
   assign idx      = count_m1[IDX_W-1:0];
   assign cand     = (count_ff >= CNT_W'(2));
   assign is_max   = (prev_ff > prev_prev_ff && prev_ff >= sample)
                  || (prev_ff >= prev_prev_ff && prev_ff > sample);
   assign is_min   = (prev_ff < prev_prev_ff && prev_ff <= sample)
                  || (prev_ff <= prev_prev_ff && prev_ff < sample);
   assign max_near = {{DIST_W{1'b0}}, idx - max_idx_ff} < {{IDX_W{1'b0}}, min_peak_dist};
   assign min_near = {{DIST_W{1'b0}}, idx - min_idx_ff} < {{IDX_W{1'b0}}, min_peak_dist};

   always_comb begin
      max_idx_in   = max_idx_ff;
      max_val_in   = max_val_ff;
      max_valid_in = max_valid_ff;
      min_idx_in   = min_idx_ff;
      min_val_in   = min_val_ff;
      min_valid_in = min_valid_ff;
      conf_v       = 1'b0;
      conf         = '0;
      if (cand) begin
         if (is_max) begin
            if (max_valid_ff && max_near) begin
               if (prev_ff > max_val_ff) begin
                  max_idx_in = idx;
                  max_val_in = prev_ff;
               end
            end else begin
               conf_v          = max_valid_ff;
               conf.peak_index = to_out(max_idx_ff);
               conf.is_maximum = 1'b1;
               max_idx_in      = idx;
               max_val_in      = prev_ff;
               max_valid_in    = 1'b1;
            end
         end else if (is_min) begin
            if (min_valid_ff && min_near) begin
               if (prev_ff < min_val_ff) begin
                  min_idx_in = idx;
                  min_val_in = prev_ff;
               end
            end else begin
               conf_v          = min_valid_ff;
               conf.peak_index = to_out(min_idx_ff);
               conf.is_maximum = 1'b0;
               min_idx_in      = idx;
               min_val_in      = prev_ff;
               min_valid_in    = 1'b1;
            end
         end
      end
   end

   // flush of the pending extrema at end of profile, lower index first
   always_comb begin
      e0   = '0;
      e1   = '0;
      e0_v = 1'b0;
      e1_v = 1'b0;
      if (last) begin
         if (max_valid_in && min_valid_in) begin
            e0_v = 1'b1;
            e1_v = 1'b1;
            if (min_idx_in < max_idx_in) begin
               e0.peak_index = to_out(min_idx_in);
               e1.peak_index = to_out(max_idx_in);
               e1.is_maximum = 1'b1;
            end else begin
               e0.peak_index = to_out(max_idx_in);
               e0.is_maximum = 1'b1;
               e1.peak_index = to_out(min_idx_in);
            end
         end else if (max_valid_in) begin
            e0_v          = 1'b1;
            e0.peak_index = to_out(max_idx_in);
            e0.is_maximum = 1'b1;
         end else if (min_valid_in) begin
            e0_v          = 1'b1;
            e0.peak_index = to_out(min_idx_in);
         end
      end
   end

   always_comb begin
      batch.res[0] = conf_v ? conf : e0;
      batch.res[1] = conf_v ? e0 : e1;
      batch.res[2] = e1;
      batch.count  = RES_CNT_W'(conf_v) + RES_CNT_W'(e0_v) + RES_CNT_W'(e1_v);
      if (last) begin
         case (batch.count)
            2'd1:    batch.res[0].final_result = 1'b1;
            2'd2:    batch.res[1].final_result = 1'b1;
            2'd3:    batch.res[2].final_result = 1'b1;
            default: batch.res[0].final_result = 1'b0;
         endcase
      end
   end

   always_comb begin
      prev_prev_in = prev_ff;
      prev_in      = sample;
      count_in     = (count_ff == CNT_W'(MAX_LEN)) ? count_ff : count_ff + 1'b1;
      if (last) begin
         prev_prev_in = '0;
         prev_in      = '0;
         count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         prev_prev_ff <= '0;
         count_ff     <= '0;
         max_idx_ff   <= '0;
         max_val_ff   <= '0;
         max_valid_ff <= 1'b0;
         min_idx_ff   <= '0;
         min_val_ff   <= '0;
         min_valid_ff <= 1'b0;
      end else if (fire) begin
         prev_ff      <= prev_in;
         prev_prev_ff <= prev_prev_in;
         count_ff     <= count_in;
         if (last) begin
            max_idx_ff   <= '0;
            max_val_ff   <= '0;
            max_valid_ff <= 1'b0;
            min_idx_ff   <= '0;
            min_val_ff   <= '0;
            min_valid_ff <= 1'b0;
         end else begin
            max_idx_ff   <= max_idx_in;
            max_val_ff   <= max_val_in;
            max_valid_ff <= max_valid_in;
            min_idx_ff   <= min_idx_in;
            min_val_ff   <= min_val_in;
            min_valid_ff <= min_valid_in;
         end
      end
   end

   a_final_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (batch.res[0].final_result || batch.res[1].final_result
       || batch.res[2].final_result) |-> last)
      else $error("final flag raised on an item that does not end the profile");

   a_three_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (batch.count == 2'd3) |-> (last && conf_v))
      else $error("three results without confirmation and end of profile");

   a_restart_after_end: assert property (@(posedge clock) disable iff (reset)
      (fire && last) |=> (count_ff == '0 && !max_valid_ff && !min_valid_ff))
      else $error("profile state not cleared after end of profile");

endmodule

`default_nettype wire

>>> hw/rtl/pkd_queue.sv
// result queue, takes up to three results at once and hands out one per cycle while out_ready is high
`default_nettype none

module pkd_queue
   import pkd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  batch_type  batch,
   output logic       space,
   output logic       out_valid,
   input  wire logic  out_ready,
   output res_type    out_res
);

   res_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   head_ff, head_in;
   logic [Q_PTR_W-1:0]   tail_ff, tail_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic [RES_CNT_W-1:0] push_n;
   logic                 pop;

   assign push_n    = push ? batch.count : '0;
   assign out_valid = (count_ff != '0);
   assign out_res   = mem_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign space     = (count_ff <= Q_CNT_W'(Q_DEPTH - MAX_RES));
   assign head_in   = head_ff + Q_PTR_W'(pop);
   assign tail_in   = tail_ff + Q_PTR_W'(push_n);
   assign count_in  = count_ff + Q_CNT_W'(push_n) - Q_CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RES; i++) begin
         if (RES_CNT_W'(i) < push_n) begin
            mem_ff[tail_ff + Q_PTR_W'(i)] <= batch.res[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> ({1'b0, batch.count} <= (Q_CNT_W'(Q_DEPTH) - count_ff)))
      else $error("result queue overflow");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != Q_CNT_W'(Q_DEPTH)) |-> (Q_PTR_W'(count_ff) == tail_ff - head_ff))
      else $error("queue pointers disagree with fill level");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(out_res)))
      else $error("waiting result dropped or changed");

endmodule

`default_nettype wire

>>> hw/rtl/peak_detect_min_distance.sv
// top level of the streaming peak detector with minimum peak distance
//
//  channel  direction  ports                                       carries
//  req      in         req_valid req_ready req_sample               one profile sample
//                      req_end_of_profile
//  rsp      out        rsp_valid rsp_ready rsp_peak_index           one confirmed extremum
//                      rsp_is_maximum rsp_final_result
//  csr      in         csr_valid csr_ready csr_min_peak_dist        distance register write
//
//  one item per cycle when not stalled: input register, classification into result queue
//  an item causes 0 to 3 results; the queue drains one per cycle while rsp_ready
//  is high, so bursts of results hold req_ready low until the queue has room for three more
//  an item is held in the input register, then its results are registered in the queue
//  synchronous reset clears profile state, queue and sets min_peak_dist to 5
`default_nettype none

module peak_detect_min_distance
   import pkd_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [SAMPLE_W-1:0]   req_sample,
   input  wire logic                  req_end_of_profile,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [PEAK_IDX_W-1:0]      rsp_peak_index,
   output logic                       rsp_is_maximum,
   output logic                       rsp_final_result,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [DIST_W-1:0]     csr_min_peak_dist
);

   logic [DIST_W-1:0]   dist_ff;
   logic                in_valid_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                in_last_ff;
   logic                space;
   logic                fire;
   batch_type           batch;
   res_type             out_res;

   assign fire      = in_valid_ff && space;
   assign req_ready = !in_valid_ff || fire;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_RESET;
      end else if (csr_valid && csr_ready) begin
         dist_ff <= csr_min_peak_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_sample;
         in_last_ff   <= req_end_of_profile;
      end
   end

   pkd_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .sample        (in_sample_ff),
      .last          (in_last_ff),
      .min_peak_dist (dist_ff),
      .batch         (batch)
   );

   pkd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .batch     (batch),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (out_res)
   );

   assign rsp_peak_index   = out_res.peak_index;
   assign rsp_is_maximum   = out_res.is_maximum;
   assign rsp_final_result = out_res.final_result;

endmodule

`default_nettype wire
